[sv/square_oscillator_am_pm_fm_macros.svh]
// Assertion helpers for the oscillator block.
// Both check on the rising edge of clk and are off while rst is high.
`ifndef SQUARE_OSCILLATOR_AM_PM_FM_MACROS_SVH
`define SQUARE_OSCILLATOR_AM_PM_FM_MACROS_SVH

// Condition must hold at every checked edge.
`define SQOSC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define SQOSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sqosc_pkg.sv]
`default_nettype none

package sqosc_pkg;

  localparam int PHASE_BITS  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int DEPTH_BITS  = 16;
  localparam int DEPTH_FRAC  = 12;
  localparam int FM_SHIFT    = FRAC_BITS + DEPTH_FRAC;
  localparam int PM_SHIFT    = PHASE_BITS - FRAC_BITS;
  // product of |m| and fm_depth
  localparam int K_BITS      = SAMPLE_BITS + DEPTH_BITS;
  // shared shift register: 33-bit upper half plus 32-bit lower half
  localparam int ACC_BITS    = 2 * PHASE_BITS + 1;
  localparam int ITER_BITS   = $clog2(PHASE_BITS);
  localparam int IN_BITS     = 3 * SAMPLE_BITS;

  // configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = PHASE_BITS;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_BASE_INCREMENT = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_AMPLITUDE      = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_FM_DEPTH       = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_AM_ENABLE      = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_PM_ENABLE      = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_FM_ENABLE      = 3'd5;

  localparam logic [FRAC_BITS-1:0] AMPLITUDE_RESET = 15'd32767;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KPROD,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

[sv/square_oscillator_am_pm_fm.sv]
// Square-wave oscillator with amplitude, phase and frequency modulation.
// Input stream s_axis carries one modulation sample triple per audio sample;
// output stream m_axis returns one square-wave sample per input, namely the
// sample computed on the previous input (one-sample lag).
// Configuration writes go through cfg_valid/cfg_ready (always ready) with a
// register index on cfg_addr; unknown indexes are dropped. Write only while
// the block is idle.
// Sequence: without FM (or with a zero FM sample) the block goes straight to
// its final state, where the result is loaded into the output register once
// the output is free, and then returns to idle to take a new item. With FM
// the phase step comes from a bit-serial shift-add multiplier (positive FM)
// or a restoring divider (negative FM), one bit per cycle over all 32 bits,
// after a product step and before a fix step that writes the step (with
// saturation on the multiplier side); only then is the final state reached.
// The result sits in an output register; the block accepts the next input
// while it waits. If the previous result is still not taken when the next one
// is ready, the block holds in its final state and s_axis_tready stays low.
// Reset (rst, synchronous) clears phase and held sample, drops any pending
// result and restores the configuration and control registers to reset values.
`default_nettype none

module square_oscillator_am_pm_fm (
  input  wire                              clk,
  input  wire                              rst,
  // configuration write channel
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [sqosc_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire [sqosc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  // input stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // fields from bit 0: am_sample[15:0], phase_mod[31:16], fm_sample[47:32]
  input  wire [sqosc_pkg::IN_BITS-1:0]     s_axis_tdata,
  // output stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // fields from bit 0: sample_out[15:0]
  output logic [sqosc_pkg::SAMPLE_BITS-1:0] m_axis_tdata
);

  import sqosc_pkg::*;

  // configuration registers
  logic [PHASE_BITS-1:0] base_increment;
  logic [FRAC_BITS-1:0]  amplitude;
  logic [DEPTH_BITS-1:0] fm_depth;
  logic                  am_enable;
  logic                  pm_enable;
  logic                  fm_enable;

  // oscillator state
  logic [PHASE_BITS-1:0]  phase;
  logic [SAMPLE_BITS-1:0] held_sample;

  // per-item working registers
  state_t                state;
  state_t                state_next;
  logic [FRAC_BITS-1:0]  amp;
  logic [SAMPLE_BITS-1:0] fm_mag;
  logic                  fm_neg;
  logic [PHASE_BITS-1:0] step;
  logic [PHASE_BITS-1:0] divisor;
  logic [ACC_BITS-1:0]   acc;
  logic [ITER_BITS-1:0]  cnt;

  // input fields
  logic [SAMPLE_BITS-1:0] am_sample;
  logic [SAMPLE_BITS-1:0] phase_mod;
  logic [SAMPLE_BITS-1:0] fm_sample;

  logic                   in_xfer;
  logic                   out_free;
  logic                   last_iter;
  logic                   fm_used;
  logic [FRAC_BITS-1:0]   amp_sel;
  logic [K_BITS-1:0]      k_prod;
  logic [PHASE_BITS:0]    mul_sum;
  logic [PHASE_BITS:0]    div_trial;
  logic                   div_ge;
  logic [PHASE_BITS:0]    div_rem;
  logic [2*PHASE_BITS-FM_SHIFT:0] sat_sum;
  logic [SAMPLE_BITS-1:0] new_held;

  assign am_sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign phase_mod = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign fm_sample = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign last_iter = (cnt == ITER_BITS'(PHASE_BITS - 1));
  assign fm_used   = fm_enable && (fm_sample != '0);

  // (am + 1) / 2: flip the sign bit to offset by one half, then drop the lsb
  assign amp_sel = am_enable ? {~am_sample[SAMPLE_BITS-1], am_sample[SAMPLE_BITS-2:1]}
                             : amplitude;

  // |m| * depth, taken once per item
  assign k_prod = K_BITS'(fm_mag) * K_BITS'(fm_depth);

  // multiplier: add base into the upper half when the current lsb is set
  assign mul_sum = {1'b0, acc[2*PHASE_BITS-1:PHASE_BITS]}
                 + (acc[0] ? {1'b0, base_increment} : '0);

  // divider: shift in the next numerator bit and try a subtract
  assign div_trial = {acc[2*PHASE_BITS-1:PHASE_BITS], acc[PHASE_BITS-1]};
  assign div_ge    = (div_trial >= {1'b0, divisor});
  assign div_rem   = div_ge ? (div_trial - {1'b0, divisor}) : div_trial;

  // base + (base * k >> 27), with the upper bits telling overflow
  assign sat_sum = {{(PHASE_BITS - FM_SHIFT + 1){1'b0}}, base_increment}
                 + {1'b0, acc[2*PHASE_BITS-1:FM_SHIFT]};

  assign new_held = phase[PHASE_BITS-1] ? (SAMPLE_BITS'(0) - {1'b0, amp})
                                        : {1'b0, amp};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_increment <= '0;
      amplitude      <= AMPLITUDE_RESET;
      fm_depth       <= '0;
      am_enable      <= 1'b0;
      pm_enable      <= 1'b0;
      fm_enable      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        CFG_BASE_INCREMENT: base_increment <= cfg_data[PHASE_BITS-1:0];
        CFG_AMPLITUDE:      amplitude      <= cfg_data[FRAC_BITS-1:0];
        CFG_FM_DEPTH:       fm_depth       <= cfg_data[DEPTH_BITS-1:0];
        CFG_AM_ENABLE:      am_enable      <= cfg_data[0];
        CFG_PM_ENABLE:      pm_enable      <= cfg_data[0];
        CFG_FM_ENABLE:      fm_enable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_xfer) state_next = fm_used ? ST_KPROD : ST_FIN;
      ST_KPROD: state_next = fm_neg ? ST_DIV : ST_MUL;
      ST_MUL:   if (last_iter) state_next = ST_FIX;
      ST_DIV:   if (last_iter) state_next = ST_FIX;
      ST_FIX:   state_next = ST_FIN;
      ST_FIN:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    cfg_ready     = 1'b1;
    s_axis_tready = (state == ST_IDLE);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      phase         <= '0;
      held_sample   <= '0;
      cnt           <= '0;
    end else begin
      state <= state_next;
      // phase modulation lands before the half-cycle test
      if (in_xfer && pm_enable) begin
        phase <= phase + {phase_mod[FRAC_BITS-1:0], {PM_SHIFT{1'b0}}};
      end
      if (state == ST_MUL || state == ST_DIV) begin
        cnt <= cnt + ITER_BITS'(1);
      end else begin
        cnt <= '0;
      end
      // emit the held sample, then take the new one and advance
      if (state == ST_FIN && out_free) begin
        m_axis_tvalid <= 1'b1;
        held_sample   <= new_held;
        phase         <= phase + step;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      amp    <= amp_sel;
      fm_neg <= fm_sample[SAMPLE_BITS-1];
      fm_mag <= fm_sample[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - fm_sample) : fm_sample;
      step   <= base_increment;
    end
    case (state)
      ST_KPROD: begin
        if (fm_neg) begin
          // remainder starts as base >> 5, numerator tail is base[4:0] << 27
          divisor <= PHASE_BITS'(k_prod) + (PHASE_BITS'(1) << FM_SHIFT);
          acc     <= {{(PHASE_BITS - FM_SHIFT + 1){1'b0}}, base_increment,
                      {FM_SHIFT{1'b0}}};
        end else begin
          acc <= {{(PHASE_BITS + 1){1'b0}}, k_prod};
        end
      end
      ST_MUL: acc <= {1'b0, mul_sum, acc[PHASE_BITS-1:1]};
      ST_DIV: acc <= {div_rem, acc[PHASE_BITS-2:0], div_ge};
      ST_FIX: begin
        if (fm_neg) begin
          step <= acc[PHASE_BITS-1:0];
        end else if (sat_sum[$left(sat_sum):PHASE_BITS] != '0) begin
          step <= '1;
        end else begin
          step <= sat_sum[PHASE_BITS-1:0];
        end
      end
      default: ;
    endcase
    if (state == ST_FIN && out_free) begin
      m_axis_tdata <= held_sample;
    end
  end

  // checks
  `include "square_oscillator_am_pm_fm_macros.svh"

  `SQOSC_ASSERT_NEXT(a_accept_busy, in_xfer, state != ST_IDLE, "idle right after a transfer")
  `SQOSC_ASSERT_NEXT(a_fin_holds, state == ST_FIN && !out_free, state == ST_FIN, "result dropped while output stalled")
  `SQOSC_ASSERT_NEXT(a_out_source, state != ST_FIN && !m_axis_tvalid, !m_axis_tvalid, "output valid without a finished item")

endmodule

`default_nettype wire
